// ===== hdl/bppt_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bppt_pkg
// Shared types and constants for the burst power period table builder.
// ---------------------------------------------------------------------------
package bppt_pkg;

    localparam int PW    = 7;   // power percent
    localparam int TOPW  = 24;  // counter TOP word
    localparam int CCW   = 25;  // carrier clocks
    localparam int LHW   = 12;  // candidate period totals
    localparam int NCW   = 14;  // candidate power units
    localparam int DVW   = 32;  // divider dividend / quotient
    localparam int DSW   = 25;  // divider divisor / remainder
    localparam int MW    = 25;  // multiplier operand
    localparam int CFGIW = 3;
    localparam int CFGDW = 25;

    localparam logic [CFGIW-1:0] REG_STARTUP_PERIODS = 3'd0;
    localparam logic [CFGIW-1:0] REG_STARTUP_POWER   = 3'd1;
    localparam logic [CFGIW-1:0] REG_MIN_POWER       = 3'd2;
    localparam logic [CFGIW-1:0] REG_MAX_POWER       = 3'd3;
    localparam logic [CFGIW-1:0] REG_CONT_POWER      = 3'd4;
    localparam logic [CFGIW-1:0] REG_MIN_BLANK       = 3'd5;
    localparam logic [CFGIW-1:0] REG_CARRIER_CLOCKS  = 3'd6;
    localparam logic [CFGIW-1:0] REG_MAX_TOP         = 3'd7;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CHK, ST_BR, ST_A_WAIT, ST_A_LOHI, ST_B_CHK, ST_B_WAIT,
        ST_B_LOHI, ST_N_PA, ST_N_PB, ST_N_EC, ST_N_EB, ST_N_TC, ST_N_TB,
        ST_N_DEC, ST_FIN, ST_BL_CHK, ST_BL_MAXB_WAIT, ST_BL_MAXB,
        ST_BL_CHUNK_WAIT, ST_BL_CLAMP, ST_BL_MIN, ST_BL_BASE_WAIT, ST_BL_BASE,
        ST_BL_TOP, ST_BL_TOP1, ST_FAIL, ST_EMIT
    } t_state;

    typedef enum logic [4:0] {
        CMD_NONE, CMD_LOAD, CMD_CHK, CMD_BR, CMD_A_LOHI, CMD_B_CHK, CMD_B_LOHI,
        CMD_N_PA, CMD_N_PB, CMD_N_EC, CMD_N_EB, CMD_N_TC, CMD_N_TB, CMD_N_DEC,
        CMD_FIN, CMD_BL_CHK, CMD_BL_MAXB, CMD_BL_CLAMP, CMD_BL_MIN,
        CMD_BL_BASE, CMD_BL_TOP, CMD_BL_TOP1, CMD_FAIL, CMD_EMIT
    } t_cmd;

    typedef struct packed {
        logic p_zero;
        logic base_fail;
        logic cont;
        logic branch_a;
        logic full;
        logic p_ge_max;
        logic hi_ne_lo;
        logic maxb_bad;
        logic blank_zero;
        logic base_bad;
        logic div_busy;
        logic out_free;
        logic emit_last;
    } t_status;

endpackage
`default_nettype wire

// ===== hdl/bppt_div.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bppt_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module bppt_div
    import bppt_pkg::*;
(
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [DVW-1:0] i_dividend,
    input  wire logic [DSW-1:0] i_divisor,
    output logic                o_busy,
    output logic [DVW-1:0]      o_quotient,
    output logic [DSW-1:0]      o_remainder
);

    localparam int CNTW = $clog2(DVW + 1);

    logic [CNTW-1:0] r_cnt;
    logic [DVW-1:0]  r_quo;
    logic [DSW:0]    r_rem;
    logic [DSW-1:0]  r_dsr;
    logic [DSW:0]    shifted;
    logic            take;

    always_comb begin
        shifted = {r_rem[DSW-1:0], r_quo[DVW-1]};
        take    = shifted >= {1'b0, r_dsr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNTW'(DVW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[DVW-2:0], take};
            r_rem <= take ? (shifted - {1'b0, r_dsr}) : shifted;
        end
    end

    assign o_busy      = (r_cnt != '0);
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem[DSW-1:0];

endmodule
`default_nettype wire

// ===== hdl/bppt_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bppt_ctrl
// Sequencer for clamping, burst sizing, blank splitting and table output.
// ---------------------------------------------------------------------------
module bppt_ctrl
    import bppt_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire t_status i_status,
    output logic         o_in_ready,
    output t_cmd         o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:          if (i_in_valid) n_state = ST_CHK;
            ST_CHK: begin
                if (i_status.p_zero)         n_state = ST_EMIT;
                else if (i_status.base_fail) n_state = ST_FAIL;
                else if (i_status.cont)      n_state = ST_EMIT;
                else                         n_state = ST_BR;
            end
            ST_BR:            n_state = i_status.branch_a ? ST_A_WAIT : ST_B_CHK;
            ST_A_WAIT:        if (!i_status.div_busy) n_state = ST_A_LOHI;
            ST_A_LOHI:        n_state = i_status.hi_ne_lo ? ST_N_PA : ST_FIN;
            ST_B_CHK: begin
                if (i_status.full)          n_state = ST_FAIL;
                else if (i_status.p_ge_max) n_state = ST_FIN;
                else                        n_state = ST_B_WAIT;
            end
            ST_B_WAIT:        if (!i_status.div_busy) n_state = ST_B_LOHI;
            ST_B_LOHI:        n_state = i_status.hi_ne_lo ? ST_N_PA : ST_FIN;
            ST_N_PA:          n_state = ST_N_PB;
            ST_N_PB:          n_state = ST_N_EC;
            ST_N_EC:          n_state = ST_N_EB;
            ST_N_EB:          n_state = ST_N_TC;
            ST_N_TC:          n_state = ST_N_TB;
            ST_N_TB:          n_state = ST_N_DEC;
            ST_N_DEC:         n_state = ST_FIN;
            ST_FIN:           n_state = ST_BL_CHK;
            ST_BL_CHK:        n_state = i_status.full ? ST_FAIL : ST_BL_MAXB_WAIT;
            ST_BL_MAXB_WAIT:  if (!i_status.div_busy) n_state = ST_BL_MAXB;
            ST_BL_MAXB: begin
                if (i_status.maxb_bad)        n_state = ST_FAIL;
                else if (i_status.blank_zero) n_state = ST_EMIT;
                else                          n_state = ST_BL_CHUNK_WAIT;
            end
            ST_BL_CHUNK_WAIT: if (!i_status.div_busy) n_state = ST_BL_CLAMP;
            ST_BL_CLAMP:      n_state = ST_BL_MIN;
            ST_BL_MIN:        n_state = ST_BL_BASE_WAIT;
            ST_BL_BASE_WAIT:  if (!i_status.div_busy) n_state = ST_BL_BASE;
            ST_BL_BASE:       n_state = i_status.base_bad ? ST_FAIL : ST_BL_TOP;
            ST_BL_TOP:        n_state = ST_BL_TOP1;
            ST_BL_TOP1:       n_state = ST_EMIT;
            ST_FAIL:          n_state = ST_EMIT;
            ST_EMIT:          if (i_status.out_free && i_status.emit_last) n_state = ST_IDLE;
            default:          n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = CMD_NONE;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd      = i_in_valid ? CMD_LOAD : CMD_NONE;
            end
            ST_CHK:      o_cmd = CMD_CHK;
            ST_BR:       o_cmd = CMD_BR;
            ST_A_LOHI:   o_cmd = CMD_A_LOHI;
            ST_B_CHK:    o_cmd = CMD_B_CHK;
            ST_B_LOHI:   o_cmd = CMD_B_LOHI;
            ST_N_PA:     o_cmd = CMD_N_PA;
            ST_N_PB:     o_cmd = CMD_N_PB;
            ST_N_EC:     o_cmd = CMD_N_EC;
            ST_N_EB:     o_cmd = CMD_N_EB;
            ST_N_TC:     o_cmd = CMD_N_TC;
            ST_N_TB:     o_cmd = CMD_N_TB;
            ST_N_DEC:    o_cmd = CMD_N_DEC;
            ST_FIN:      o_cmd = CMD_FIN;
            ST_BL_CHK:   o_cmd = CMD_BL_CHK;
            ST_BL_MAXB:  o_cmd = CMD_BL_MAXB;
            ST_BL_CLAMP: o_cmd = CMD_BL_CLAMP;
            ST_BL_MIN:   o_cmd = CMD_BL_MIN;
            ST_BL_BASE:  o_cmd = CMD_BL_BASE;
            ST_BL_TOP:   o_cmd = CMD_BL_TOP;
            ST_BL_TOP1:  o_cmd = CMD_BL_TOP1;
            ST_FAIL:     o_cmd = CMD_FAIL;
            ST_EMIT:     o_cmd = CMD_EMIT;
            default:     o_cmd = CMD_NONE;
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/bppt_dp.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bppt_dp
// Datapath: config registers, shared multiplier and divider, output register.
// ---------------------------------------------------------------------------
module bppt_dp
    import bppt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cmd             i_cmd,
    output t_status               o_status,
    input  wire logic             i_cfg_valid,
    input  wire logic [CFGIW-1:0] i_cfg_index,
    input  wire logic [CFGDW-1:0] i_cfg_data,
    input  wire logic [7:0]       i_power_request,
    input  wire logic             i_out_ready,
    output logic                  o_out_valid,
    output logic                  o_has_entry,
    output logic [TOPW-1:0]       o_top_value,
    output logic                  o_last,
    output logic                  o_failed,
    output logic [PW-1:0]         o_applied_power
);

    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] TE_C = CW'(TABLE_ENTRIES);

    function automatic logic [DVW-1:0] absdiff(input logic [DVW-1:0] a,
                                               input logic [DVW-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    // configuration
    logic [4:0]      r_sp;
    logic [PW-1:0]   r_spp, r_minp, r_maxp, r_contp;
    logic [7:0]      r_mbp;
    logic [CCW-1:0]  r_cc;
    logic [TOPW-1:0] r_mct;

    // working registers
    logic [PW-1:0]   r_p;
    logic [LHW-1:0]  r_units;
    logic [8:0]      r_bt;
    logic [15:0]     r_num;
    logic            r_is_a;
    logic [LHW-1:0]  r_lo, r_hi, r_best, r_dc, r_db;
    logic [NCW-1:0]  r_nc, r_nb;
    logic [DVW-1:0]  r_ma, r_mb, r_ec, r_eb;
    logic [DVW-1:0]  r_blank;
    logic [CW-1:0]   r_nfull, r_chunks, r_longer, r_idx;
    logic [DSW-1:0]  r_maxb, r_base;
    logic [TOPW-1:0] r_topf, r_topb, r_topb1;
    logic            r_fail;

    logic            r_out_valid;
    logic            r_has, r_last, r_failed;
    logic [TOPW-1:0] r_top;
    logic [PW-1:0]   r_applied;

    // divider
    logic           div_start, div_busy;
    logic [DVW-1:0] div_a, div_q;
    logic [DSW-1:0] div_b, div_r;

    bppt_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_a),
        .i_divisor   (div_b),
        .o_busy      (div_busy),
        .o_quotient  (div_q),
        .o_remainder (div_r)
    );

    // combinational helpers
    logic [PW-1:0]     clamp_p, cap_p;
    logic [CCW-1:0]    topf_c;
    logic [15:0]       pbt;
    logic              rem_nz, full, p_ge_max, branch_a;
    logic [CW-1:0]     maxx, avail, b_lo, b_hi, total, jdx;
    logic [LHW-1:0]    a_lo, a_hi;
    logic [NCW-1:0]    b_nc_hi, b_nc_lo;
    logic [MW-1:0]     mul_a, mul_b;
    logic [2*MW-1:0]   prod;
    logic              pick, maxb_bad, base_bad, out_free, emit_last;
    logic [DVW-1:0]    blank_m, chunks_c, mb, blank_f;
    logic [TOPW-1:0]   entry_top;

    always_comb begin
        cap_p   = ({1'b0, i_power_request} > {2'b0, r_maxp}) ? r_maxp
                                                          : i_power_request[PW-1:0];
        clamp_p = (cap_p != '0 && cap_p < r_minp) ? r_minp : cap_p;

        topf_c   = r_cc - 1'b1;
        pbt      = 16'(r_p) * 16'(r_bt);
        branch_a = pbt <= 16'(r_units);
        rem_nz   = (div_r != '0);
        full     = r_nfull >= TE_C;
        p_ge_max = r_p >= r_maxp;
        maxx     = TE_C - r_nfull - 1'b1;
        avail    = TE_C - r_nfull;

        a_lo = (div_q[LHW-1:0] < LHW'(r_bt)) ? LHW'(r_bt) : div_q[LHW-1:0];
        a_hi = a_lo + LHW'(rem_nz);

        b_lo    = (div_q > DVW'(maxx)) ? maxx : div_q[CW-1:0];
        b_hi    = b_lo + CW'(rem_nz && (b_lo < maxx));
        b_nc_hi = NCW'(r_units) + NCW'(b_hi) * NCW'(r_maxp);
        b_nc_lo = NCW'(r_units) + NCW'(b_lo) * NCW'(r_maxp);

        // one shared multiplier
        mul_a = '0;
        mul_b = '0;
        case (i_cmd)
            CMD_N_PA:     begin mul_a = MW'(r_p);  mul_b = MW'(r_dc); end
            CMD_N_PB:     begin mul_a = MW'(r_p);  mul_b = MW'(r_db); end
            CMD_N_EC:     begin
                mul_a = MW'(absdiff(DVW'(r_nc), r_ma));
                mul_b = MW'(r_db);
            end
            CMD_N_EB:     begin
                mul_a = MW'(absdiff(DVW'(r_nb), r_mb));
                mul_b = MW'(r_dc);
            end
            CMD_N_TC:     begin mul_a = MW'(r_nc); mul_b = MW'(r_db); end
            CMD_N_TB:     begin mul_a = MW'(r_nb); mul_b = MW'(r_dc); end
            CMD_BL_CLAMP: begin mul_a = r_maxb;    mul_b = MW'(avail); end
            CMD_BL_TOP:   begin mul_a = r_base;    mul_b = r_cc; end
            default:      begin mul_a = '0;        mul_b = '0; end
        endcase
        prod = mul_a * mul_b;

        // tie goes to the lower modeled power
        pick = (r_ec != r_eb) ? (r_ec < r_eb) : (r_ma < r_mb);

        maxb_bad = (div_q == '0) || (div_q < DVW'(r_mbp));
        blank_m  = (r_blank < DVW'(r_mbp)) ? DVW'(r_mbp) : r_blank;
        chunks_c = div_q + DVW'(rem_nz);
        mb       = DVW'(16'(r_chunks) * 16'(r_mbp));
        blank_f  = (r_blank < mb) ? mb : r_blank;
        base_bad = (div_q < DVW'(r_mbp)) || ((div_q + DVW'(rem_nz)) > DVW'(r_maxb));

        total     = r_nfull + r_chunks;
        jdx       = r_idx - r_nfull;
        entry_top = (r_idx < r_nfull) ? r_topf : ((jdx < r_longer) ? r_topb1 : r_topb);
        out_free  = !r_out_valid || i_out_ready;
        emit_last = r_fail || (total == '0) || (r_idx == total - 1'b1);

        div_start = 1'b0;
        div_a     = '0;
        div_b     = '0;
        case (i_cmd)
            CMD_BR: begin
                div_start = branch_a;
                div_a     = DVW'(r_units);
                div_b     = DSW'(r_p);
            end
            CMD_B_CHK: begin
                div_start = !full && !p_ge_max;
                div_a     = DVW'(r_num);
                div_b     = DSW'(r_maxp - r_p);
            end
            CMD_BL_CHK: begin
                div_start = !full;
                div_a     = DVW'(r_mct) + 1'b1;
                div_b     = r_cc;
            end
            CMD_BL_MAXB: begin
                div_start = !maxb_bad && (blank_m != '0);
                div_a     = blank_m;
                div_b     = div_q[DSW-1:0];
            end
            CMD_BL_MIN: begin
                div_start = 1'b1;
                div_a     = blank_f;
                div_b     = DSW'(r_chunks);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_status.p_zero     = (r_p == '0);
        o_status.base_fail  = (r_cc == '0) || (8'(r_sp) > 8'(TABLE_ENTRIES)) ||
                              (topf_c > {1'b0, r_mct});
        o_status.cont       = r_p >= r_contp;
        o_status.branch_a   = branch_a;
        o_status.full       = full;
        o_status.p_ge_max   = p_ge_max;
        o_status.hi_ne_lo   = r_is_a ? rem_nz : (b_hi != b_lo);
        o_status.maxb_bad   = maxb_bad;
        o_status.blank_zero = (blank_m == '0);
        o_status.base_bad   = base_bad;
        o_status.div_busy   = div_busy;
        o_status.out_free   = out_free;
        o_status.emit_last  = emit_last;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp    <= 5'd8;
            r_spp   <= 7'd50;
            r_minp  <= 7'd5;
            r_maxp  <= 7'd100;
            r_contp <= 7'd90;
            r_mbp   <= 8'd2;
            r_cc    <= 25'd480;
            r_mct   <= 24'hFFFFFF;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_STARTUP_PERIODS: r_sp    <= i_cfg_data[4:0];
                REG_STARTUP_POWER:   r_spp   <= i_cfg_data[PW-1:0];
                REG_MIN_POWER:       r_minp  <= i_cfg_data[PW-1:0];
                REG_MAX_POWER:       r_maxp  <= i_cfg_data[PW-1:0];
                REG_CONT_POWER:      r_contp <= i_cfg_data[PW-1:0];
                REG_MIN_BLANK:       r_mbp   <= i_cfg_data[7:0];
                REG_CARRIER_CLOCKS:  r_cc    <= i_cfg_data[CCW-1:0];
                REG_MAX_TOP:         r_mct   <= i_cfg_data[TOPW-1:0];
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_LOAD: r_p <= clamp_p;
            CMD_CHK: begin
                r_units  <= LHW'(r_sp) * LHW'(r_spp);
                r_bt     <= 9'(r_sp) + 9'(r_mbp);
                r_topf   <= topf_c[TOPW-1:0];
                r_nfull  <= (r_p == '0) ? '0 : CW'(r_sp);
                r_chunks <= '0;
                r_longer <= '0;
                r_idx    <= '0;
                r_fail   <= 1'b0;
                r_blank  <= DVW'(r_mbp);
            end
            CMD_BR: begin
                r_is_a <= branch_a;
                r_num  <= pbt - 16'(r_units);
            end
            CMD_A_LOHI: begin
                r_lo   <= a_lo;
                r_hi   <= a_hi;
                r_best <= a_lo;
                r_nc   <= NCW'(r_units);
                r_nb   <= NCW'(r_units);
                r_dc   <= a_hi;
                r_db   <= a_lo;
            end
            CMD_B_CHK:  r_best <= LHW'(maxx);
            CMD_B_LOHI: begin
                r_lo   <= LHW'(b_lo);
                r_hi   <= LHW'(b_hi);
                r_best <= LHW'(b_lo);
                r_nc   <= b_nc_hi;
                r_nb   <= b_nc_lo;
                r_dc   <= LHW'(r_bt) + LHW'(b_hi);
                r_db   <= LHW'(r_bt) + LHW'(b_lo);
            end
            CMD_N_PA: r_ma <= DVW'(prod);
            CMD_N_PB: r_mb <= DVW'(prod);
            CMD_N_EC: r_ec <= DVW'(prod);
            CMD_N_EB: r_eb <= DVW'(prod);
            CMD_N_TC: r_ma <= DVW'(prod);
            CMD_N_TB: r_mb <= DVW'(prod);
            CMD_N_DEC: r_best <= pick ? r_hi : r_lo;
            CMD_FIN: begin
                if (r_is_a) begin
                    r_blank <= DVW'(r_best - LHW'(r_sp));
                end else begin
                    r_nfull <= r_nfull + CW'(r_best);
                end
            end
            CMD_BL_MAXB: begin
                r_maxb  <= div_q[DSW-1:0];
                r_blank <= blank_m;
            end
            CMD_BL_CLAMP: begin
                if (chunks_c > DVW'(avail)) begin
                    r_chunks <= avail;
                    r_blank  <= DVW'(prod);
                end else begin
                    r_chunks <= chunks_c[CW-1:0];
                end
            end
            CMD_BL_MIN:  r_blank <= blank_f;
            CMD_BL_BASE: begin
                r_base   <= div_q[DSW-1:0];
                r_longer <= div_r[CW-1:0];
            end
            CMD_BL_TOP:  r_topb  <= TOPW'(prod[CCW-1:0] - 1'b1);
            CMD_BL_TOP1: r_topb1 <= r_topb + r_cc[TOPW-1:0];
            CMD_FAIL:    r_fail  <= 1'b1;
            CMD_EMIT:    if (out_free) r_idx <= r_idx + 1'b1;
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd == CMD_EMIT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_EMIT && out_free) begin
            r_applied <= r_p;
            if (r_fail || total == '0) begin
                r_has    <= 1'b0;
                r_top    <= '0;
                r_last   <= 1'b1;
                r_failed <= r_fail;
            end else begin
                r_has    <= 1'b1;
                r_top    <= entry_top;
                r_last   <= (r_idx == total - 1'b1);
                r_failed <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_has_entry     = r_has;
    assign o_top_value     = r_top;
    assign o_last          = r_last;
    assign o_failed        = r_failed;
    assign o_applied_power = r_applied;

endmodule
`default_nettype wire

// ===== hdl/burst_power_period_table_builder.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// burst_power_period_table_builder
// Clamps a power request and streams the burst table of PWM TOP words.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+---------------------------
//  in       | sink      | i_in_valid / o_in_ready   | i_power_request
//  out      | source    | o_out_valid / i_out_ready | has_entry, top_value, last,
//           |           |                           | failed, applied_power
//  cfg      | sink      | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// A zero-power request goes straight from the first check to the emit state; a
// configuration fault found at once passes the fail state first. The 32-step
// serial divider is used up to four times per request; table entries then leave
// at one per cycle while the output is not stalled.
// One request is worked at a time; the next is taken once the last item of the
// previous one sits in the output register.
// Reset is synchronous and restores the default configuration.
// A stalled output holds the sequencer in its emit state.
// ---------------------------------------------------------------------------
module burst_power_period_table_builder
    import bppt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic [7:0]       i_power_request,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic                  o_has_entry,
    output logic [TOPW-1:0]       o_top_value,
    output logic                  o_last,
    output logic                  o_failed,
    output logic [PW-1:0]         o_applied_power,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [CFGIW-1:0] i_cfg_index,
    input  wire logic [CFGDW-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    bppt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    bppt_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_power_request (i_power_request),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_has_entry     (o_has_entry),
        .o_top_value     (o_top_value),
        .o_last          (o_last),
        .o_failed        (o_failed),
        .o_applied_power (o_applied_power)
    );

    a_fail_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_failed) |-> (o_last && !o_has_entry))
        else $error("failed item not a lone final item");

    a_no_entry_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_has_entry) |-> (o_top_value == '0 && o_last))
        else $error("entry-less item carries a top value");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second request taken while one is in work");

    a_no_div_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !status.div_busy)
        else $error("divider busy while idle");

endmodule
`default_nettype wire
